// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Types, sizes and codes shared by the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

   // Queue depth and derived widths
   localparam int CAPACITY  = 16;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int SUM_W     = IDX_W + 1;

   // Field widths
   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int TAG_W     = 16;
   localparam int COUNT_W   = 5;
   localparam int STATUS_W  = 2;

   // Action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic               action;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [TAG_W-1:0]   tag;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   out_year;
      logic [MONTH_W-1:0]  out_month;
      logic [DAY_W-1:0]    out_day;
      logic [TAG_W-1:0]    out_tag;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CMP,
      S_POP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;   // capture new entry, start scan at the tail
      logic rd_head;    // read the head entry
      logic wr_new;     // write new entry at scan position, finish insert
      logic wr_shift;   // move read entry up one place, step scan down
      logic pop_done;   // return head entry, drop it from the queue
      logic rsp_empty;  // report pop on empty queue
      logic rsp_full;   // report dropped insert
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic pos_zero;
      logic rd_greater;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/ssq_ctrl.sv
// ----------------------------------------------------------------------------
// ssq_ctrl
// Sequencer for the queue: accepts items, steps the insertion scan and sequences pops.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_ctrl
   import ssq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    action,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (action == ACT_POP) begin
                  if (sts.empty) begin
                     cmd.rsp_empty = 1'b1;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in    = S_POP;
                  end
               end else begin
                  if (sts.full) begin
                     cmd.rsp_full = 1'b1;
                  end else begin
                     cmd.load_req = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (sts.pos_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.rd_greater) begin
               cmd.wr_shift = 1'b1;
               state_in     = S_SCAN;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_POP: begin
            cmd.pop_done = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/ssq_datapath.sv
// ----------------------------------------------------------------------------
// ssq_datapath
// Circular entry memory, head pointer, fill count, scan position and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_datapath
   import ssq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   entry_type mem [CAPACITY];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] pos_in;
   entry_type        new_ff;
   entry_type        new_in;
   entry_type        rdata_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             strobe_ff;
   logic             strobe_in;

   logic [CNT_W-1:0] rd_lpos;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;

   // Map a position in queue order to a memory address
   function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] lpos);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + SUM_W'(lpos);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Addresses: read head or the entry just below the scan position
   assign rd_lpos = cmd.rd_head ? '0 : (pos_ff - CNT_W'(1));
   assign rd_addr = to_phys(head_ff, rd_lpos);
   assign wr_addr = to_phys(head_ff, pos_ff);

   // Entry memory, registered read
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (cmd.wr_new) begin
         mem[wr_addr] <= new_ff;
      end else if (cmd.wr_shift) begin
         mem[wr_addr] <= rdata_ff;
      end
   end

   // Status for the controller
   assign sts.empty      = (count_ff == '0);
   assign sts.full       = (count_ff == CNT_W'(CAPACITY));
   assign sts.pos_zero   = (pos_ff == '0);
   assign sts.rd_greater = (rdata_ff.year > new_ff.year);

   // Next values of queue state and result
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      pos_in    = pos_ff;
      new_in    = new_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;

      if (cmd.load_req) begin
         new_in.year  = req_data.year;
         new_in.month = req_data.month;
         new_in.day   = req_data.day;
         new_in.tag   = req_data.tag;
         pos_in       = count_ff;
      end

      if (cmd.wr_shift) begin
         pos_in = pos_ff - CNT_W'(1);
      end

      if (cmd.wr_new) begin
         count_in      = count_ff + CNT_W'(1);
         strobe_in     = 1'b1;
         rsp_in        = '0;
         rsp_in.count  = COUNT_W'(count_ff + CNT_W'(1));
         rsp_in.status = STAT_OK;
      end

      if (cmd.pop_done) begin
         count_in         = count_ff - CNT_W'(1);
         head_in          = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : (head_ff + IDX_W'(1));
         strobe_in        = 1'b1;
         rsp_in.out_year  = rdata_ff.year;
         rsp_in.out_month = rdata_ff.month;
         rsp_in.out_day   = rdata_ff.day;
         rsp_in.out_tag   = rdata_ff.tag;
         rsp_in.count     = COUNT_W'(count_ff - CNT_W'(1));
         rsp_in.status    = STAT_OK;
      end

      if (cmd.rsp_empty) begin
         strobe_in     = 1'b1;
         rsp_in        = '0;
         rsp_in.status = STAT_EMPTY;
      end

      if (cmd.rsp_full) begin
         strobe_in     = 1'b1;
         rsp_in        = '0;
         rsp_in.count  = COUNT_W'(CAPACITY);
         rsp_in.status = STAT_FULL;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         head_ff   <= '0;
         pos_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         head_ff   <= head_in;
         pos_ff    <= pos_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_ff <= new_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Priority queue ordered by ascending year; equal years leave in arrival
// order. Items insert an entry or pop the head entry, one result per item.
//
//   channel   ports                    handshake
//   request   req_data                 taken when start && !busy
//   result    rsp_data                 valid for one cycle with rsp_strobe
//
// Pop: S_POP returns the head entry and drops it; the registered result shows once busy falls.
// Insert: each held entry with a larger year moves up one place through S_SCAN
// (one memory read), then S_CMP (compare and write); busy stays high until the
// new entry is written, and the result follows the last write.
// Pop on empty and insert on full are answered the cycle after accept.
// Reset (synchronous) empties the queue; the memory needs no clearing.
// The result side has no backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue
   import ssq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   ssq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   ssq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/ssq_checker.sv
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks on item acceptance and result reporting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ssq_checker
   import ssq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   logic accept;
   logic payload_zero;
   logic full_rsp;
   logic full_ok;
   logic empty_rsp;
   logic empty_ok;

   assign accept       = start && !busy && (req_data.action inside {ACT_POP, ACT_INSERT});
   assign payload_zero = (rsp_data.out_year == '0) && (rsp_data.out_month == '0) &&
                         (rsp_data.out_day == '0) && (rsp_data.out_tag == '0);

   // Classify full and empty reports
   assign full_rsp  = rsp_strobe && (rsp_data.status == STAT_FULL);
   assign full_ok   = payload_zero && (rsp_data.count == COUNT_W'(CAPACITY));
   assign empty_rsp = rsp_strobe && (rsp_data.status == STAT_EMPTY);
   assign empty_ok  = payload_zero && (rsp_data.count == '0);

   // Every accepted item is either answered next cycle or keeps the block busy
   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, (rsp_strobe || busy))

   // A result is only shown once the item is fully done
   `ASSERT_IMPLIES(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // Busy only rises after an accepted item
   `ASSERT_IMPLIES(a_busy_cause, clock, reset, $rose(busy), $past(start))

   // Dropped insert reports a full queue and no payload
   `ASSERT_IMPLIES(a_full_rsp, clock, reset, full_rsp, full_ok)

   // Pop on empty reports an empty queue and no payload
   `ASSERT_IMPLIES(a_empty_rsp, clock, reset, empty_rsp, empty_ok)

endmodule

bind stable_sorted_priority_queue ssq_checker u_ssq_checker (.*);

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_sorted_priority_queue. A small scoreboard
// keeps its own sorted copy of the queue, predicts the result of every
// accepted item and compares each returned result field by field. Stimulus
// covers field extremes, equal-year ordering, pop on empty and insert on full,
// then random insert/pop mixes that sweep the fill level end to end.
// ----------------------------------------------------------------------------

module tb;
   import ssq_pkg::*;

   localparam int ITEM_TARGET = 1050;
   localparam int QUIET_TAIL  = 150;
   localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;
   localparam int CYCLE_LIMIT = 400000;

   // Sorted-queue predictor and result checker
   class queue_scoreboard;
      entry_type held[CAPACITY];
      int        held_count;
      rsp_type   owed_results[$];
      int        errors;
      int        n_insert, n_pop, n_empty, n_full, deepest;

      function new();
         held_count = 0;
         errors = 0;
         n_insert = 0;
         n_pop = 0;
         n_empty = 0;
         n_full = 0;
         deepest = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Apply one accepted item to the held copy and queue its expected result
      function void note_item(req_type r);
         rsp_type   exp_rsp;
         entry_type head;
         int        pos;
         exp_rsp = '0;
         if (r.action == ACT_POP) begin
            if (held_count == 0) begin
               exp_rsp.status = STAT_EMPTY;
               n_empty++;
            end else begin
               head = held[0];
               for (int i = 1; i < held_count; i++) held[i-1] = held[i];
               held_count--;
               exp_rsp.out_year  = head.year;
               exp_rsp.out_month = head.month;
               exp_rsp.out_day   = head.day;
               exp_rsp.out_tag   = head.tag;
               exp_rsp.status    = STAT_OK;
               n_pop++;
            end
         end else begin
            if (held_count >= CAPACITY) begin
               exp_rsp.status = STAT_FULL;
               n_full++;
            end else begin
               // first slot with a strictly larger year keeps ties in arrival order
               pos = 0;
               while (pos < held_count && held[pos].year <= r.year) pos++;
               for (int i = held_count; i > pos; i--) held[i] = held[i-1];
               held[pos].year  = r.year;
               held[pos].month = r.month;
               held[pos].day   = r.day;
               held[pos].tag   = r.tag;
               held_count++;
               exp_rsp.status = STAT_OK;
               n_insert++;
               if (held_count > deepest) deepest = held_count;
            end
         end
         exp_rsp.count = held_count[COUNT_W-1:0];
         owed_results.push_back(exp_rsp);
      endfunction

      // Compare one returned result with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("tb: unexpected result year=%0d month=%0d day=%0d tag=%h count=%0d status=%0d",
                        got.out_year, got.out_month, got.out_day, got.out_tag,
                        got.count, got.status);
            return;
         end
         exp_rsp = owed_results.pop_front();
         if (got.out_year != exp_rsp.out_year || got.out_month != exp_rsp.out_month ||
             got.out_day != exp_rsp.out_day || got.out_tag != exp_rsp.out_tag ||
             got.count != exp_rsp.count || got.status != exp_rsp.status) begin
            errors++;
            if (errors <= 10) begin
               $display("tb: mismatch at %0t", $realtime);
               $display("   expected year=%0d month=%0d day=%0d tag=%h count=%0d status=%0d",
                        exp_rsp.out_year, exp_rsp.out_month, exp_rsp.out_day,
                        exp_rsp.out_tag, exp_rsp.count, exp_rsp.status);
               $display("   actual   year=%0d month=%0d day=%0d tag=%h count=%0d status=%0d",
                        got.out_year, got.out_month, got.out_day, got.out_tag,
                        got.count, got.status);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   queue_scoreboard sb;
   int cycle_count = 0;
   int gap_pct = 0;
   int items_sent = 0;

   stable_sorted_priority_queue uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watch both channels at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_item(req_data);
         if (rsp_strobe) sb.check_result(rsp_data);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic req_type make_req(logic act, int yr, int mo, int dy, int tg);
      req_type r;
      r.action = act;
      r.year   = yr[YEAR_W-1:0];
      r.month  = mo[MONTH_W-1:0];
      r.day    = dy[DAY_W-1:0];
      r.tag    = tg[TAG_W-1:0];
      return r;
   endfunction

   // Pick a year: mostly a narrow band at either end for ties, sometimes anywhere
   function automatic int pick_year(int span);
      int y;
      if (span == 0) begin
         y = $urandom_range(0, 16383);
      end else begin
         y = $urandom_range(0, span);
         if ($urandom_range(0, 1) == 1) y = 16383 - y;
      end
      return y;
   endfunction

   // Hold start and the item until taken, then maybe idle for a burst
   task automatic issue(req_type r);
      int gap;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if ($urandom_range(1, 100) <= gap_pct) begin
         gap = $urandom_range(1, 12);
         start    <= 1'b0;
         req_data <= make_req(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                              $urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int burst, ins_pct, span, roll;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 25;

      // Directed: empty pop, field extremes, equal years, fill to full, refused insert
      issue(make_req(ACT_POP, 0, 0, 0, 0));
      issue(make_req(ACT_INSERT, 100, 1, 1, 16'h0001));
      issue(make_req(ACT_INSERT, 100, 2, 2, 16'h0002));
      issue(make_req(ACT_INSERT, 0, 15, 31, 16'hFFFF));
      issue(make_req(ACT_INSERT, 16383, 0, 0, 16'h0000));
      issue(make_req(ACT_INSERT, 9999, 12, 31, 16'hAAAA));
      issue(make_req(ACT_INSERT, 100, 3, 3, 16'h0003));
      issue(make_req(ACT_POP, 16383, 15, 31, 16'hFFFF));
      for (int i = 0; i < 11; i++)
         issue(make_req(ACT_INSERT, 50 + (i % 3) * 50, i + 1, i + 10, 16'h5500 + i));
      issue(make_req(ACT_INSERT, 1, 5, 5, 16'h5555));
      issue(make_req(ACT_POP, 0, 0, 0, 0));
      issue(make_req(ACT_POP, 0, 0, 0, 0));

      // Random bursts, each with its own insert bias, year spread and idling
      while (items_sent < ITEM_TARGET) begin
         burst = $urandom_range(20, 60);
         roll  = $urandom_range(0, 2);
         ins_pct = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
         roll  = $urandom_range(0, 3);
         span  = (roll == 0) ? 0 : (roll == 1) ? 3 : (roll == 2) ? 20 : 500;
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         for (int i = 0; i < burst && items_sent < ITEM_TARGET; i++) begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL) gap_pct = 0;
            if ($urandom_range(1, 100) <= ins_pct)
               issue(make_req(ACT_INSERT, pick_year(span), $urandom_range(0, 15),
                              $urandom_range(0, 31), $urandom_range(0, 65535)));
            else
               issue(make_req(ACT_POP, $urandom_range(0, 16383), $urandom_range(0, 15),
                              $urandom_range(0, 31), $urandom_range(0, 65535)));
         end
      end
      start <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("tb: %0d items: %0d inserts, %0d pops, %0d pops on empty, %0d refused when full",
               items_sent, sb.n_insert, sb.n_pop, sb.n_empty, sb.n_full);
      $display("tb: deepest fill %0d of %0d, %0d mismatches", sb.deepest, CAPACITY, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ssq_pkg.sv
rtl/ssq_ctrl.sv
rtl/ssq_datapath.sv
rtl/stable_sorted_priority_queue.sv
rtl/ssq_checker.sv
sim/tb.sv
